/* rtl/core/mfq_pkg.sv */
// ----------------------------------------------------------------------------
// mfq_pkg
// shared constants, state encoding and controller/datapath interface types
// ----------------------------------------------------------------------------
package mfq_pkg;

    localparam int MAX_JOBS = 32;
    localparam int IDX_W    = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int BURST_W  = 16;
    localparam int TIME_W   = 21;
    localparam int SUM_W    = 26;
    localparam int SLICE_W  = 8;
    localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd5;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SJ,
        S_SJC,
        S_SKA,
        S_SKB,
        S_SW,
        S_RA,
        S_RB,
        S_RC,
        S_RD,
        S_EM,
        S_NX,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic sort_init;
        logic rank_init;
        logic rd_k;
        logic cap_j;
        logic cmp;
        logic rank_wr;
        logic run_init;
        logic cap_job;
        logic exec;
        logic emit;
        logic next;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic j_last;
        logic k_last;
        logic i_last;
        logic proc;
        logic fin;
        logic out_free;
        logic emit_last;
    } sts_t;

endpackage

/* rtl/core/mfq_ctrl.sv */
// ----------------------------------------------------------------------------
// mfq_ctrl
// sequencer for load, rank sort and level simulation phases
// ----------------------------------------------------------------------------
module mfq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic           s_tlast,
    output logic           s_tready,
    input  mfq_pkg::sts_t  sts,
    output mfq_pkg::cmd_t  cmd
);

    mfq_pkg::state_t state_reg;
    mfq_pkg::state_t state_next;
    logic            accept;

    assign accept = s_tvalid && (state_reg == mfq_pkg::S_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfq_pkg::S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mfq_pkg::S_LOAD: if (accept && s_tlast) state_next = mfq_pkg::S_SJ;
            mfq_pkg::S_SJ:   state_next = mfq_pkg::S_SJC;
            mfq_pkg::S_SJC:  state_next = mfq_pkg::S_SKA;
            mfq_pkg::S_SKA:  state_next = mfq_pkg::S_SKB;
            mfq_pkg::S_SKB:  state_next = sts.k_last ? mfq_pkg::S_SW : mfq_pkg::S_SKA;
            mfq_pkg::S_SW:   state_next = sts.j_last ? mfq_pkg::S_RA : mfq_pkg::S_SJ;
            mfq_pkg::S_RA:   state_next = mfq_pkg::S_RB;
            mfq_pkg::S_RB:   state_next = mfq_pkg::S_RC;
            mfq_pkg::S_RC:   state_next = mfq_pkg::S_RD;
            mfq_pkg::S_RD:
            begin
                if (sts.proc && sts.fin) state_next = mfq_pkg::S_EM;
                else                     state_next = mfq_pkg::S_NX;
            end
            mfq_pkg::S_EM:
            begin
                if (sts.out_free)
                    state_next = sts.emit_last ? mfq_pkg::S_DONE : mfq_pkg::S_NX;
            end
            mfq_pkg::S_NX:   state_next = mfq_pkg::S_RA;
            mfq_pkg::S_DONE: state_next = mfq_pkg::S_LOAD;
            default:         state_next = mfq_pkg::S_LOAD;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            mfq_pkg::S_LOAD:
            begin
                s_tready      = 1'b1;
                cmd.load      = accept;
                cmd.sort_init = accept && s_tlast;
            end
            mfq_pkg::S_SJ:   cmd.rank_init = 1'b1;
            mfq_pkg::S_SJC:
            begin
                cmd.cap_j = 1'b1;
                cmd.rd_k  = 1'b1;
            end
            mfq_pkg::S_SKA:  cmd.rd_k = 1'b1;
            mfq_pkg::S_SKB:  cmd.cmp = 1'b1;
            mfq_pkg::S_SW:
            begin
                cmd.rank_wr  = 1'b1;
                cmd.run_init = sts.j_last;
            end
            mfq_pkg::S_RA:   ;
            mfq_pkg::S_RB:   cmd.cap_job = 1'b1;
            mfq_pkg::S_RC:   ;
            mfq_pkg::S_RD:   cmd.exec = 1'b1;
            mfq_pkg::S_EM:   cmd.emit = sts.out_free;
            mfq_pkg::S_NX:   cmd.next = 1'b1;
            mfq_pkg::S_DONE: cmd.clear = 1'b1;
            default:         ;
        endcase
    end

endmodule

/* rtl/core/mfq_dpath.sv */
// ----------------------------------------------------------------------------
// mfq_dpath
// job stores, sorted order list, counters, simulated clock and result register
// ----------------------------------------------------------------------------
module mfq_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mfq_pkg::cmd_t                cmd,
    input  logic [mfq_pkg::BURST_W-1:0]  burst_in,
    input  logic [mfq_pkg::SLICE_W-1:0]  slice,
    input  logic                         out_ready,
    output mfq_pkg::sts_t                sts,
    output logic                         out_valid,
    output logic [mfq_pkg::IDX_W-1:0]    out_index,
    output logic [mfq_pkg::TIME_W-1:0]   out_time,
    output logic [mfq_pkg::SUM_W-1:0]    out_sum,
    output logic                         out_last
);

    localparam int IW = mfq_pkg::IDX_W;
    localparam int CW = mfq_pkg::CNT_W;
    localparam int BW = mfq_pkg::BURST_W;
    localparam int TW = mfq_pkg::TIME_W;
    localparam int SW = mfq_pkg::SUM_W;

    logic [BW-1:0] bmem [mfq_pkg::MAX_JOBS];
    logic [BW-1:0] rmem [mfq_pkg::MAX_JOBS];
    logic [IW-1:0] lmem [mfq_pkg::MAX_JOBS];

    logic [CW-1:0] n_reg, emit_reg;
    logic [IW-1:0] j_reg, k_reg, rank_reg, i_reg, job_reg;
    logic [1:0]    lvl_reg;
    logic          first_reg;
    logic [BW-1:0] bj_reg, bq_reg, rq_reg;
    logic [IW-1:0] lq_reg;
    logic [TW-1:0] time_reg;
    logic [SW-1:0] sum_reg;

    logic [IW-1:0] n_m1;
    logic [BW-1:0] slice_ext, run, rem_new;
    logic          less, room;
    logic [SW-1:0] sum_next;
    logic [TW-1:0] time_next;

    assign n_m1      = IW'(n_reg - CW'(1));
    assign room      = n_reg < CW'(mfq_pkg::MAX_JOBS);
    assign slice_ext = (slice == '0) ? BW'(1) : BW'(slice);
    assign run       = (rq_reg < slice_ext) ? rq_reg : slice_ext;
    assign rem_new   = rq_reg - run;
    assign time_next = time_reg + TW'(run);
    assign sum_next  = sum_reg + SW'(time_reg);
    assign less      = (bq_reg < bj_reg) || ((bq_reg == bj_reg) && (k_reg < j_reg));

    assign sts.j_last    = (j_reg == n_m1);
    assign sts.k_last    = (k_reg == n_m1);
    assign sts.i_last    = (i_reg == n_m1);
    assign sts.proc      = (first_reg && (lvl_reg == 2'd0)) || (rq_reg != '0);
    assign sts.fin       = (rem_new == '0);
    assign sts.out_free  = !out_valid || out_ready;
    assign sts.emit_last = ((emit_reg + CW'(1)) == n_reg);

    // memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            bmem[n_reg[IW-1:0]] <= burst_in;
        end
        bq_reg <= bmem[cmd.rd_k ? k_reg : j_reg];

        if (cmd.load && room)
        begin
            rmem[n_reg[IW-1:0]] <= burst_in;
        end
        else if (cmd.exec && sts.proc)
        begin
            rmem[job_reg] <= rem_new;
        end
        rq_reg <= rmem[job_reg];

        if (cmd.rank_wr)
        begin
            lmem[rank_reg] <= j_reg;
        end
        lq_reg <= lmem[i_reg];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap_j)
        begin
            bj_reg <= bq_reg;
        end
        if (cmd.cap_job)
        begin
            job_reg <= (first_reg && !lvl_reg[1]) ? i_reg : lq_reg;
        end
        if (cmd.emit)
        begin
            out_index <= job_reg;
            out_time  <= time_reg;
            out_sum   <= sum_next;
            out_last  <= sts.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= '0;
            emit_reg  <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            rank_reg  <= '0;
            i_reg     <= '0;
            lvl_reg   <= '0;
            first_reg <= 1'b1;
            time_reg  <= '0;
            sum_reg   <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cmd.load && room)   n_reg <= n_reg + CW'(1);
            if (cmd.sort_init)      j_reg <= '0;
            if (cmd.rank_init)
            begin
                k_reg    <= '0;
                rank_reg <= '0;
            end
            if (cmd.cmp)
            begin
                k_reg <= k_reg + IW'(1);
                if (less) rank_reg <= rank_reg + IW'(1);
            end
            if (cmd.rank_wr)        j_reg <= j_reg + IW'(1);
            if (cmd.run_init)
            begin
                i_reg     <= '0;
                lvl_reg   <= '0;
                first_reg <= 1'b1;
                emit_reg  <= '0;
            end
            if (cmd.exec && sts.proc) time_reg <= time_next;
            if (cmd.next)
            begin
                if (sts.i_last)
                begin
                    i_reg   <= '0;
                    lvl_reg <= lvl_reg + 2'd1;
                    if (lvl_reg == 2'd3) first_reg <= 1'b0;
                end
                else
                begin
                    i_reg <= i_reg + IW'(1);
                end
            end
            if (cmd.emit)
            begin
                sum_reg   <= sum_next;
                emit_reg  <= emit_reg + CW'(1);
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
            if (cmd.clear)
            begin
                n_reg    <= '0;
                time_reg <= '0;
                sum_reg  <= '0;
            end
        end
    end

endmodule

/* rtl/core/multilevel_feedback_queue_sim_top.sv */
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_sim_top
// batch simulator of a four-level feedback queue scheduler
// ----------------------------------------------------------------------------
// Jobs are loaded one item per cycle on the slave stream (burst time in
// tdata, tlast marks the final job); up to 32 jobs are kept and any beyond
// that are dropped. The item with tlast starts the simulation and the input
// stays not ready until the batch is finished. The simulation first ranks
// all n jobs by (burst, index) with one shared comparator, then walks the
// levels 0..3 pass after pass; every job slot of a level visit takes the
// steps list read, job capture, store read, update and step whether or not
// that job is still live, plus an emit step per completion record that
// waits while the master side holds the previous record. A batch needs
// ceil(max_burst/(4*quantum)) passes of four levels, at least one, so its
// run time is set by the sort and by the walk over every job slot at each
// level. One record per job leaves on the master stream in completion
// order, tlast on the final one. The quantum is written on the cfg channel
// while idle; a value of zero acts as one.
module multilevel_feedback_queue_sim_top (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream: tdata[15:0] burst_time
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,        // last_job
    // master stream: tdata[4:0] job_index, [25:5] completion_time,
    // [51:26] total_turnaround, [55:52] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic        m_tlast,        // last_result
    // configuration: quantum granted at each level visit
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    mfq_pkg::cmd_t cmd;
    mfq_pkg::sts_t sts;

    logic [mfq_pkg::SLICE_W-1:0] slice_reg;
    logic [mfq_pkg::IDX_W-1:0]   out_index;
    logic [mfq_pkg::TIME_W-1:0]  out_time;
    logic [mfq_pkg::SUM_W-1:0]   out_sum;

    // config register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_reg <= mfq_pkg::SLICE_RESET;
        end
        else if (cfg_valid)
        begin
            slice_reg <= cfg_data;
        end
    end

    mfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mfq_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .burst_in  (s_tdata),
        .slice     (slice_reg),
        .out_ready (m_tready),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_index (out_index),
        .out_time  (out_time),
        .out_sum   (out_sum),
        .out_last  (m_tlast)
    );

    // pack result fields, lowest field first
    assign m_tdata = {4'b0, out_sum, out_time, out_index};

`ifndef SYNTHESIS
    // a record is only loaded when the output register can take it
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("record emitted over a pending one");

    // input is never taken while a batch is being simulated
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec || cmd.cmp) |-> !s_tready)
        else $error("input ready during simulation");

    // the last record of a batch is followed by the batch clear
    a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.emit_last) |=> cmd.clear)
        else $error("batch not cleared after last record");
`endif

endmodule

/* tb/sv/mfq_checker.sv */
// ----------------------------------------------------------------------------
// mfq_checker
// watches the job, record and time slice channels, predicts each batch and
// compares the completion records field by field
// ----------------------------------------------------------------------------
module mfq_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int          errors,
    output int          records_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [mfq_pkg::IDX_W-1:0]  job;
        logic [mfq_pkg::TIME_W-1:0] done_at;
        logic [mfq_pkg::SUM_W-1:0]  total;
        logic                       last;
    } record_t;

    record_t                       record_q[$];
    logic [mfq_pkg::BURST_W-1:0]   job_burst[mfq_pkg::MAX_JOBS];
    logic [mfq_pkg::SLICE_W-1:0]   quantum;
    int                            n_loaded;

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    // run the whole batch: four levels in order, pass after pass
    task automatic schedule_batch();
        int                          lvl[4][$];
        int                          remain[mfq_pkg::MAX_JOBS];
        int                          slice_len;
        int                          best;
        int                          job;
        int                          run;
        int                          n;
        logic [mfq_pkg::TIME_W-1:0]  now;
        logic [mfq_pkg::SUM_W-1:0]   sum;
        record_t                     r;
        slice_len = (quantum == 0) ? 1 : quantum;
        now = '0;
        sum = '0;
        n = 0;
        for (int j = 0; j < n_loaded; j++)
        begin
            remain[j] = job_burst[j];
            lvl[0].push_back(j);
        end
        while (lvl[0].size() + lvl[1].size() + lvl[2].size() + lvl[3].size() != 0)
        begin
            for (int l = 0; l < 4; l++)
            begin
                while (lvl[l].size() != 0)
                begin
                    best = 0;
                    if (l >= 2)
                    begin
                        // shortest original burst first, lower index on a tie
                        for (int k = 1; k < lvl[l].size(); k++)
                        begin
                            if (job_burst[lvl[l][k]] < job_burst[lvl[l][best]] ||
                                (job_burst[lvl[l][k]] == job_burst[lvl[l][best]] &&
                                 lvl[l][k] < lvl[l][best]))
                                best = k;
                        end
                    end
                    job = lvl[l][best];
                    lvl[l].delete(best);
                    run = (remain[job] < slice_len) ? remain[job] : slice_len;
                    now = now + mfq_pkg::TIME_W'(run);
                    remain[job] -= run;
                    if (remain[job] > 0)
                        lvl[(l + 1) % 4].push_back(job);
                    else
                    begin
                        sum = sum + mfq_pkg::SUM_W'(now);
                        r.job = mfq_pkg::IDX_W'(job);
                        r.done_at = now;
                        r.total = sum;
                        r.last = 1'b0;
                        record_q.push_back(r);
                        n++;
                    end
                end
            end
        end
        if (n > 0)
            record_q[record_q.size() - 1].last = 1'b1;
        n_loaded = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        record_t got;
        record_t want;
        if (!rst_n)
        begin
            quantum  <= mfq_pkg::SLICE_RESET;
            n_loaded = 0;
            errors   = 0;
            record_q.delete();
            records_pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                quantum <= cfg_data;
            if (s_tvalid && s_tready)
            begin
                if (n_loaded < mfq_pkg::MAX_JOBS)
                begin
                    job_burst[n_loaded] = s_tdata;
                    n_loaded++;
                end
                if (s_tlast)
                    schedule_batch();
            end
            if (m_tvalid && m_tready)
            begin
                got.job     = m_tdata[4:0];
                got.done_at = m_tdata[25:5];
                got.total   = m_tdata[51:26];
                got.last    = m_tlast;
                if (record_q.size() == 0)
                    report($sformatf("unexpected record job %0d", got.job));
                else
                begin
                    want = record_q.pop_front();
                    if (got.job !== want.job)
                        report($sformatf("job_index %0d want %0d", got.job, want.job));
                    if (got.done_at !== want.done_at)
                        report($sformatf("completion_time %0d want %0d",
                                         got.done_at, want.done_at));
                    if (got.total !== want.total)
                        report($sformatf("total_turnaround %0d want %0d",
                                         got.total, want.total));
                    if (got.last !== want.last)
                        report($sformatf("last_result %0b want %0b", got.last, want.last));
                    if (m_tdata[55:52] !== 4'b0)
                        report("tdata padding not zero");
                end
            end
            records_pending = record_q.size();
        end
    end

endmodule

/* tb/sv/multilevel_feedback_queue_sim_top_tb.sv */
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_sim_top_tb
// batch stimulus for the feedback queue scheduler with random idling
// ----------------------------------------------------------------------------
// Batches of jobs go in on the slave stream; the checker predicts every
// completion record. Directed batches cover zero bursts, the largest burst,
// the capacity overflow and the extreme time slices; random batches follow.
module multilevel_feedback_queue_sim_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // a batch of 32 jobs of the largest burst at a quantum of one walks
    // about 16384 passes over every job slot before its first record
    localparam int IDLE_LIMIT  = 50000000;
    localparam int HOLD_CYCLES = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;
    int          errors;
    int          records_pending;

    // idling control
    bit          sender_jitter = 1'b1;
    bit          receiver_jitter = 1'b1;
    bit          hold_receiver = 1'b0;
    int          quiet_cycles = 0;

    always #5 clk = ~clk;

    multilevel_feedback_queue_sim_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    mfq_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .records_pending(records_pending)
    );

    // receiver: ready stalls in bursts, and one long hold on request
    initial
    begin
        int stall;
        bit held_off;
        held_off = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_receiver && !held_off)
            begin
                // long hold counted here while the sender keeps offering
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (receiver_jitter && $urandom_range(0, 3) == 0)
            begin
                stall = $urandom_range(1, 12);
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // watchdog: cycles with no accepted item anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one job item; may idle first
    task automatic send_job(input logic [15:0] burst, input logic last);
        int gap;
        if (sender_jitter && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= burst;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
    endtask

    // wait for every record of the batch, then a settle gap
    task automatic drain();
        drop_valid();
        @(posedge clk);
        while (records_pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_slice(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // bursts kept small so batches stay short, a few large
    function automatic logic [15:0] pick_burst();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return 16'($urandom_range(0, 65535));
            2:       return 16'($urandom_range(200, 2000));
            default: return 16'($urandom_range(0, 60));
        endcase
    endfunction

    task automatic send_batch(input int count);
        for (int i = 0; i < count; i++)
            send_job(pick_burst(), i == count - 1);
        drain();
    endtask

    initial
    begin
        int sent;
        int count;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default slice: zero bursts, the largest burst, equal bursts
        send_job(16'd0, 1'b0);
        send_job(16'hFFFF, 1'b0);
        send_job(16'd7, 1'b0);
        send_job(16'd7, 1'b0);
        send_job(16'd0, 1'b1);
        drain();
        // single job batch
        send_job(16'd12, 1'b1);
        drain();

        // zero slice acts as one
        set_slice(8'd0);
        send_job(16'd3, 1'b0);
        send_job(16'd1, 1'b0);
        send_job(16'h5555, 1'b0);
        send_job(16'hAAAA, 1'b1);
        drain();

        // largest slice
        set_slice(8'd255);
        send_job(16'd1000, 1'b0);
        send_job(16'd255, 1'b0);
        send_job(16'd256, 1'b1);
        drain();

        // capacity: 32 jobs kept, the rest dropped; the receiver holds off
        // while the next batch is already offered and stalls at the input
        set_slice(8'd1);
        hold_receiver = 1'b1;
        for (int i = 0; i < 36; i++)
            send_job(16'($urandom_range(0, 6)), i == 35);
        send_batch(6);
        sent = 55;

        // random batches, slice changed between them
        while (sent < 480)
        begin
            set_slice(8'($urandom_range(0, 255)));
            if (sent > 400)
            begin
                sender_jitter = 1'b0;
                receiver_jitter = 1'b0;
            end
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34)
                                                : $urandom_range(1, 10);
            send_batch(count);
            sent += count;
        end

        repeat (50) @(posedge clk);
        if (errors == 0 && records_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
